/* hw/rtl/rsp_pkg.sv */
// ----------------------------------------------------------------------------
// Reply parser package
// Shared constants, byte codes and the result record of the reply stream
// parser.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int unsigned RSP_LEN_BITS_DEF = 32;
  localparam int unsigned RSP_OQ_DEPTH     = 4;

  localparam logic [31:0] RSP_MAX_ARG_LEN_RST = 32'd65536;

  localparam logic [7:0] CH_ERR   = 8'h2d;
  localparam logic [7:0] CH_STAT  = 8'h2b;
  localparam logic [7:0] CH_INT   = 8'h3a;
  localparam logic [7:0] CH_BULK  = 8'h24;
  localparam logic [7:0] CH_ARRAY = 8'h2a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  localparam logic [1:0] KIND_ERR  = 2'd0;
  localparam logic [1:0] KIND_STAT = 2'd1;
  localparam logic [1:0] KIND_INT  = 2'd2;
  localparam logic [1:0] KIND_BULK = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TYPE    = 2'd1;
  localparam logic [1:0] ERR_DIGIT   = 2'd2;
  localparam logic [1:0] ERR_TOOLONG = 2'd3;

  localparam int unsigned RSP_TRAIL_LEN = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic [1:0] item_kind;
    logic       arg_end;
    logic       null_arg;
    logic       reply_end;
    logic [1:0] error_code;
  } rsp_res_t;

endpackage

/* hw/rtl/rsp_if.sv */
// ----------------------------------------------------------------------------
// Reply parser channels
// Valid/ready channels for received bytes and for parsed result items.
// ----------------------------------------------------------------------------
interface rsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic [1:0] item_kind;
  logic       arg_end;
  logic       null_arg;
  logic       reply_end;
  logic [1:0] error_code;

  modport source (
    output valid, output data_byte, output has_byte, output item_kind,
    output arg_end, output null_arg, output reply_end, output error_code,
    input ready
  );
  modport sink (
    input valid, input data_byte, input has_byte, input item_kind,
    input arg_end, input null_arg, input reply_end, input error_code,
    output ready
  );
endinterface

/* hw/rtl/rsp_outq.sv */
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two result items per cycle from the
// parser and hands them out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module rsp_outq
  import rsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  rsp_res_t         res0_i,
  input  rsp_res_t         res1_i,
  output logic             space_o,
  rsp_out_if.source        out_o
);

  localparam int unsigned PW = $clog2(RSP_OQ_DEPTH);
  localparam int unsigned CW = $clog2(RSP_OQ_DEPTH + 1);

  rsp_res_t        mem_q [RSP_OQ_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            pop;
  rsp_res_t        head;

  assign pop     = out_o.valid && out_o.ready;
  assign space_o = (cnt_q <= CW'(RSP_OQ_DEPTH - 2));
  assign head    = mem_q[rd_q];

  assign out_o.valid      = (cnt_q != '0);
  assign out_o.data_byte  = head.data_byte;
  assign out_o.has_byte   = head.has_byte;
  assign out_o.item_kind  = head.item_kind;
  assign out_o.arg_end    = head.arg_end;
  assign out_o.null_arg   = head.null_arg;
  assign out_o.reply_end  = head.reply_end;
  assign out_o.error_code = head.error_code;

  always_comb begin
    wr_d  = wr_q + PW'(push_n_i);
    rd_d  = rd_q + PW'(pop);
    cnt_d = cnt_q + CW'(push_n_i) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_q + PW'(1)] <= res1_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(RSP_OQ_DEPTH))
    else $error("result queue count exceeds its depth");

  a_pair_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n_i == 2'd2 |-> cnt_q <= CW'(RSP_OQ_DEPTH - 2))
    else $error("two results pushed without room for both");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pop && push_n_i == 2'd0) |=> cnt_q == $past(cnt_q))
    else $error("result queue count moved without push or pop");

endmodule

/* hw/rtl/rsp_parse.sv */
// ----------------------------------------------------------------------------
// Reply parser core
// Per-byte state machine that decodes type bytes, length lines and content,
// and produces up to two result items for each accepted byte.
// ----------------------------------------------------------------------------
module rsp_parse
  import rsp_pkg::*;
#(
  parameter int unsigned LEN_BITS = RSP_LEN_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        space_i,
  rsp_in_if.sink      in_i,
  output logic [1:0]  push_n_o,
  output rsp_res_t    res0_o,
  output rsp_res_t    res1_o
);

  localparam int unsigned CMPW = (LEN_BITS > 32) ? LEN_BITS : 32;

  localparam logic [2:0] PH_TYPE   = 3'd0;
  localparam logic [2:0] PH_LINE   = 3'd1;
  localparam logic [2:0] PH_BLEN   = 3'd2;
  localparam logic [2:0] PH_BDATA  = 3'd3;
  localparam logic [2:0] PH_BTRAIL = 3'd4;
  localparam logic [2:0] PH_ALEN   = 3'd5;

  logic [2:0]          phase_q, phase_d;
  logic [LEN_BITS-1:0] elem_q, elem_d;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic                neg_q, neg_d;
  logic                cr_q, cr_d;
  logic [1:0]          kind_q, kind_d;
  logic                in_arr_q, in_arr_d;
  logic [31:0]         max_q;

  logic                acc;
  logic [7:0]          b;
  logic                is_digit;
  logic [LEN_BITS+3:0] prod;
  logic                ovf;
  logic                too_long;
  logic                bulk_pos;
  logic                do_fin, fin_null, fin_one;
  logic                do_fail;
  logic [1:0]          fail_code;
  logic [LEN_BITS-1:0] fin_e, fin_e1;
  logic                fin_rend;
  logic [1:0]          n_res;
  rsp_res_t            res0, res1;

  function automatic rsp_res_t mk_byte(input logic [7:0] v, input logic [1:0] k);
    rsp_res_t r;
    r           = '0;
    r.data_byte = v;
    r.has_byte  = 1'b1;
    r.item_kind = k;
    return r;
  endfunction

  assign acc       = in_i.valid && in_i.ready;
  assign in_i.ready = space_i;
  assign b         = in_i.rx_byte;
  assign is_digit  = (b >= CH_D0) && (b <= CH_D9);
  assign prod      = ({4'b0000, len_q} << 3) + ({4'b0000, len_q} << 1)
                     + (LEN_BITS + 4)'(b[3:0]);
  assign ovf       = (prod[LEN_BITS+3:LEN_BITS] != 4'd0);
  assign too_long  = CMPW'(prod[LEN_BITS-1:0]) > CMPW'(max_q);
  assign bulk_pos  = (phase_q == PH_BLEN) && !neg_q;

  always_comb begin
    phase_d   = phase_q;
    elem_d    = elem_q;
    len_d     = len_q;
    neg_d     = neg_q;
    cr_d      = cr_q;
    kind_d    = kind_q;
    in_arr_d  = in_arr_q;
    res0      = '0;
    res1      = '0;
    n_res     = 2'd0;
    do_fin    = 1'b0;
    fin_null  = 1'b0;
    fin_one   = 1'b0;
    do_fail   = 1'b0;
    fail_code = ERR_NONE;

    unique case (phase_q)
      PH_LINE: begin
        if (cr_q) begin
          if (b == CH_LF) begin
            do_fin = 1'b1;
          end else begin
            res0  = mk_byte(CH_CR, kind_q);
            n_res = 2'd1;
            if (b != CH_CR) begin
              cr_d  = 1'b0;
              res1  = mk_byte(b, kind_q);
              n_res = 2'd2;
            end
          end
        end else if (b == CH_CR) begin
          cr_d = 1'b1;
        end else begin
          res0  = mk_byte(b, kind_q);
          n_res = 2'd1;
        end
      end
      PH_BLEN, PH_ALEN: begin
        if (cr_q) begin
          if (b == CH_LF) begin
            cr_d = 1'b0;
            if (phase_q == PH_BLEN) begin
              if (neg_q) begin
                do_fin   = 1'b1;
                fin_null = 1'b1;
              end else if (len_q == '0) begin
                phase_d = PH_BTRAIL;
                len_d   = LEN_BITS'(RSP_TRAIL_LEN);
              end else begin
                phase_d = PH_BDATA;
              end
            end else begin
              if (neg_q) begin
                kind_d   = KIND_BULK;
                do_fin   = 1'b1;
                fin_null = 1'b1;
                fin_one  = 1'b1;
              end else if (len_q == '0) begin
                res0.reply_end = 1'b1;
                n_res          = 2'd1;
                elem_d         = LEN_BITS'(1);
                in_arr_d       = 1'b0;
                phase_d        = PH_TYPE;
              end else begin
                elem_d   = len_q;
                in_arr_d = 1'b1;
                phase_d  = PH_TYPE;
              end
            end
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_DIGIT;
          end
        end else if (b == CH_CR) begin
          cr_d = 1'b1;
        end else if (b == CH_MINUS && len_q == '0 && !neg_q) begin
          neg_d = 1'b1;
        end else if (is_digit) begin
          if (ovf) begin
            if (bulk_pos) begin
              do_fail   = 1'b1;
              fail_code = ERR_TOOLONG;
            end else begin
              len_d = '1;
            end
          end else begin
            len_d = prod[LEN_BITS-1:0];
            if (bulk_pos && too_long) begin
              do_fail   = 1'b1;
              fail_code = ERR_TOOLONG;
            end
          end
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_DIGIT;
        end
      end
      PH_BDATA: begin
        res0  = mk_byte(b, kind_q);
        n_res = 2'd1;
        len_d = len_q - LEN_BITS'(1);
        if (len_d == '0) begin
          phase_d = PH_BTRAIL;
          len_d   = LEN_BITS'(RSP_TRAIL_LEN);
        end
      end
      PH_BTRAIL: begin
        len_d = len_q - LEN_BITS'(1);
        if (len_d == '0) begin
          do_fin = 1'b1;
        end
      end
      default: begin
        phase_d = PH_TYPE;
        cr_d    = 1'b0;
        case (b)
          CH_ERR: begin
            kind_d  = KIND_ERR;
            phase_d = PH_LINE;
          end
          CH_STAT: begin
            kind_d  = KIND_STAT;
            phase_d = PH_LINE;
          end
          CH_INT: begin
            kind_d  = KIND_INT;
            phase_d = PH_LINE;
          end
          CH_BULK: begin
            kind_d  = KIND_BULK;
            phase_d = PH_BLEN;
            len_d   = '0;
            neg_d   = 1'b0;
          end
          CH_ARRAY: begin
            if (in_arr_q) begin
              do_fail   = 1'b1;
              fail_code = ERR_TYPE;
            end else begin
              kind_d  = KIND_ERR;
              phase_d = PH_ALEN;
              len_d   = '0;
              neg_d   = 1'b0;
            end
          end
          default: begin
            do_fail   = 1'b1;
            fail_code = ERR_TYPE;
          end
        endcase
      end
    endcase

    fin_e    = fin_one ? LEN_BITS'(1) : elem_q;
    fin_e1   = ((fin_e == '0) ? LEN_BITS'(1) : fin_e) - LEN_BITS'(1);
    fin_rend = (fin_e1 == '0);

    if (do_fin) begin
      res0           = '0;
      res0.item_kind = kind_d;
      res0.arg_end   = 1'b1;
      res0.null_arg  = fin_null;
      res0.reply_end = fin_rend;
      n_res          = 2'd1;
      elem_d         = fin_rend ? LEN_BITS'(1) : fin_e1;
      if (fin_rend) begin
        in_arr_d = 1'b0;
      end
      phase_d = PH_TYPE;
      cr_d    = 1'b0;
    end

    if (do_fail) begin
      res0            = '0;
      res0.error_code = fail_code;
      res1            = '0;
      n_res           = 2'd1;
      phase_d         = PH_TYPE;
      elem_d          = LEN_BITS'(1);
      len_d           = '0;
      neg_d           = 1'b0;
      cr_d            = 1'b0;
      kind_d          = KIND_ERR;
      in_arr_d        = 1'b0;
    end
  end

  assign push_n_o = acc ? n_res : 2'd0;
  assign res0_o   = res0;
  assign res1_o   = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TYPE;
      elem_q   <= LEN_BITS'(1);
      len_q    <= '0;
      neg_q    <= 1'b0;
      cr_q     <= 1'b0;
      kind_q   <= KIND_ERR;
      in_arr_q <= 1'b0;
      max_q    <= RSP_MAX_ARG_LEN_RST;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (acc) begin
        phase_q  <= phase_d;
        elem_q   <= elem_d;
        len_q    <= len_d;
        neg_q    <= neg_d;
        cr_q     <= cr_d;
        kind_q   <= kind_d;
        in_arr_q <= in_arr_d;
      end
    end
  end

  a_fail_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && do_fail |=> phase_q == PH_TYPE && !in_arr_q && elem_q == LEN_BITS'(1))
    else $error("parser state not cleared after an error");

  a_pair_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && n_res == 2'd2 |-> phase_q == PH_LINE && cr_q)
    else $error("two results outside a held carriage return in a line");

  a_arr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_arr_q |-> elem_q != '0)
    else $error("array open with no elements left");

endmodule

/* hw/rtl/resp_reply_stream_parser.sv */
// ----------------------------------------------------------------------------
// Reply stream parser
// Parses a reply byte stream, one byte per item, into argument bytes and
// argument and reply end markers, with error reporting.
// ----------------------------------------------------------------------------
// Result items are registered in the result queue before they reach the
// output. Throughput: one byte per cycle while the queue has room for two
// items; a byte that yields two items is absorbed by the four-entry queue.
// Reset: asynchronous; parser returns to the type byte state and the length
// limit returns to 65536. Results queued at reset are dropped.
module resp_reply_stream_parser
  import rsp_pkg::*;
#(
  parameter int unsigned LEN_BITS = RSP_LEN_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  rsp_in_if.sink      in_i,
  rsp_out_if.source   out_o
);

  logic       space;
  logic [1:0] push_n;
  rsp_res_t   res0;
  rsp_res_t   res1;

  rsp_parse #(
    .LEN_BITS (LEN_BITS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .space_i     (space),
    .in_i        (in_i),
    .push_n_o    (push_n),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  rsp_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .res0_i   (res0),
    .res1_i   (res1),
    .space_o  (space),
    .out_o    (out_o)
  );

endmodule
